### design/bpq_pkg.sv
package bpq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int PRIO_WIDTH_DEF = 8;

  localparam int CAP_WIDTH   = 5;
  localparam int OCC_WIDTH   = 5;
  localparam int STAT_WIDTH  = 2;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

  localparam logic [STAT_WIDTH-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_WIDTH-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STAT_WIDTH-1:0] STATUS_UNDERFLOW = 2'd2;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  localparam logic REG_CAPACITY = 1'b0;

  // Per-cycle shift command broadcast to every slot
  typedef struct packed {
    logic ins;
    logic del;
  } bpq_op_t;

endpackage

### design/bounded_priority_queue.sv
// Bounded priority queue kept as a sorted row of slot registers, highest
// priority in front, equal priorities in arrival order. Pulse start with mode
// 0 to enqueue (data_in, priority_in) or mode 1 to dequeue. busy never rises:
// a command can be issued every cycle. Each command is registered, then
// applied to all slots in one parallel compare-and-shift, and its result
// is registered once more before it shows on done; results cannot be
// stalled, so sample them whenever done is high. status reports overflow
// (count at capacity or at DEPTH) and underflow (empty); both leave the
// queue unchanged. data_out and priority_out are zero unless a dequeue
// succeeds, occupancy is the count after the command. The capacity
// register sits at address 0; the user must write it only while no
// command is in flight, which the block itself does not enforce.
module bounded_priority_queue #(
  parameter int DEPTH      = bpq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bpq_pkg::DATA_WIDTH_DEF,
  parameter int PRIO_WIDTH = bpq_pkg::PRIO_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           mode,
  input  logic signed [DATA_WIDTH-1:0]   data_in,
  input  logic [PRIO_WIDTH-1:0]          priority_in,
  output logic                           done,
  output logic [bpq_pkg::STAT_WIDTH-1:0] status,
  output logic signed [DATA_WIDTH-1:0]   data_out,
  output logic [PRIO_WIDTH-1:0]          priority_out,
  output logic [bpq_pkg::OCC_WIDTH-1:0]  occupancy,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpq_pkg::APB_AW-1:0]     paddr,
  input  logic [bpq_pkg::APB_DW-1:0]     pwdata,
  output logic [bpq_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);
  import bpq_pkg::*;

  localparam int CNT_WIDTH = $clog2(DEPTH + 1);

  logic [CAP_WIDTH-1:0]  capacity;

  logic                  cmd_valid;
  logic                  cmd_mode;
  logic [DATA_WIDTH-1:0] cmd_data;
  logic [PRIO_WIDTH-1:0] cmd_prio;

  logic [CNT_WIDTH-1:0]  count;
  logic [CNT_WIDTH-1:0]  count_next;
  logic                  full;
  logic                  empty;
  bpq_op_t               op;

  logic                  cell_valid [DEPTH];
  logic                  cell_ge    [DEPTH];
  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic [PRIO_WIDTH-1:0] cell_prio  [DEPTH];

  logic [STAT_WIDTH-1:0] status_next;

  assign busy = 1'b0;

  bpq_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // Command register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    cmd_mode <= mode;
    cmd_data <= data_in;
    cmd_prio <= priority_in;
  end

  assign full  = (32'(count) >= 32'(capacity)) || (32'(count) >= DEPTH);
  assign empty = (count == '0);

  always_comb begin
    op          = '0;
    status_next = STATUS_OK;
    count_next  = count;
    if (cmd_mode == MODE_ENQ) begin
      if (full) begin
        status_next = STATUS_OVERFLOW;
      end else begin
        op.ins     = cmd_valid;
        count_next = count + 1'b1;
      end
    end else begin
      if (empty) begin
        status_next = STATUS_UNDERFLOW;
      end else begin
        op.del     = cmd_valid;
        count_next = count - 1'b1;
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_slot
      logic                  p_ge;
      logic [DATA_WIDTH-1:0] p_data;
      logic [PRIO_WIDTH-1:0] p_prio;
      logic [DATA_WIDTH-1:0] n_data;
      logic [PRIO_WIDTH-1:0] n_prio;

      assign cell_valid[i] = (32'(count) > 32'(i));

      if (i == 0) begin : g_head
        assign p_ge   = 1'b1;
        assign p_data = cell_data[i];
        assign p_prio = cell_prio[i];
      end else begin : g_body
        assign p_ge   = cell_ge[i-1];
        assign p_data = cell_data[i-1];
        assign p_prio = cell_prio[i-1];
      end

      if (i == DEPTH-1) begin : g_tail
        assign n_data = cell_data[i];
        assign n_prio = cell_prio[i];
      end else begin : g_mid
        assign n_data = cell_data[i+1];
        assign n_prio = cell_prio[i+1];
      end

      bpq_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .PRIO_WIDTH (PRIO_WIDTH)
      ) u_cell (
        .clk       (clk),
        .op        (op),
        .valid     (cell_valid[i]),
        .new_data  (cmd_data),
        .new_prio  (cmd_prio),
        .prev_ge   (p_ge),
        .prev_data (p_data),
        .prev_prio (p_prio),
        .next_data (n_data),
        .next_prio (n_prio),
        .ge        (cell_ge[i]),
        .data      (cell_data[i]),
        .prio      (cell_prio[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd_valid;
      if (cmd_valid) begin
        count <= count_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    status       <= status_next;
    occupancy    <= OCC_WIDTH'(count_next);
    data_out     <= op.del ? cell_data[0] : '0;
    priority_out <= op.del ? cell_prio[0] : '0;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= DEPTH)
    else $error("entry count exceeds slot count");

  a_done_follows_cmd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd_valid))
    else $error("result without a command");

  a_reject_holds_count: assert property (@(posedge clk) disable iff (rst)
    (done && status != STATUS_OK) |-> (count == $past(count)))
    else $error("rejected command changed the count");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_UNDERFLOW) |-> (occupancy == '0))
    else $error("underflow with entries held");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (32'(count) >= 2) |-> (cell_prio[0] >= cell_prio[1]))
    else $error("front slots out of priority order");

endmodule

### design/bpq_regs.sv
module bpq_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpq_pkg::APB_AW-1:0]    paddr,
  input  logic [bpq_pkg::APB_DW-1:0]    pwdata,
  output logic [bpq_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output logic [bpq_pkg::CAP_WIDTH-1:0] capacity
);
  import bpq_pkg::*;

  logic reg_sel;
  logic wr_beat;

  // Word aligned: bit 2 picks the register, low bits are ignored
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;
  assign wr_beat = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (wr_beat && (reg_sel == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_WIDTH-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_CAPACITY) begin
      prdata = {{(APB_DW-CAP_WIDTH){1'b0}}, capacity};
    end
  end

endmodule

### design/bpq_cell.sv
module bpq_cell #(
  parameter int DATA_WIDTH = bpq_pkg::DATA_WIDTH_DEF,
  parameter int PRIO_WIDTH = bpq_pkg::PRIO_WIDTH_DEF
) (
  input  logic                  clk,
  input  bpq_pkg::bpq_op_t      op,
  input  logic                  valid,
  input  logic [DATA_WIDTH-1:0] new_data,
  input  logic [PRIO_WIDTH-1:0] new_prio,
  input  logic                  prev_ge,
  input  logic [DATA_WIDTH-1:0] prev_data,
  input  logic [PRIO_WIDTH-1:0] prev_prio,
  input  logic [DATA_WIDTH-1:0] next_data,
  input  logic [PRIO_WIDTH-1:0] next_prio,
  output logic                  ge,
  output logic [DATA_WIDTH-1:0] data,
  output logic [PRIO_WIDTH-1:0] prio
);
  import bpq_pkg::*;

  logic [DATA_WIDTH-1:0] data_next;
  logic [PRIO_WIDTH-1:0] prio_next;

  // Held entry stays ahead of a new one of equal or lower priority
  assign ge = valid && (prio >= new_prio);

  always_comb begin
    data_next = data;
    prio_next = prio;
    if (op.ins && !ge) begin
      // The first slot not ahead of the new entry takes it; later ones shift down
      if (prev_ge) begin
        data_next = new_data;
        prio_next = new_prio;
      end else begin
        data_next = prev_data;
        prio_next = prev_prio;
      end
    end else if (op.del) begin
      data_next = next_data;
      prio_next = next_prio;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    prio <= prio_next;
  end

endmodule

### tb/tb_bounded_priority_queue.sv
module tb_bounded_priority_queue;
  import bpq_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam logic [APB_AW-1:0] CAP_ADDR = APB_AW'(4 * REG_CAPACITY);
  localparam logic [APB_AW-1:0] SPARE_ADDR = CAP_ADDR + APB_AW'(4);
  localparam int SEG_ITEMS = 115;
  // capacity per random segment, segment 0 in the low bits
  localparam logic [5:0][CAP_WIDTH-1:0] SEG_CAPS =
    {5'd1, 5'd9, 5'd0, 5'd16, 5'd3, 5'd31};

  typedef struct packed {
    logic [STAT_WIDTH-1:0] status;
    logic [31:0]           data_out;
    logic [7:0]            priority_out;
    logic [OCC_WIDTH-1:0]  occupancy;
  } queue_result_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [APB_AW-1:0]    addr;
    logic [CAP_WIDTH-1:0] cap;
    logic                 mode;
    logic [31:0]          data;
    logic [7:0]           prio;
    logic                 typed;
    queue_result_t        res;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic mode = MODE_ENQ;
  logic signed [31:0] data_in = '0;
  logic [7:0] priority_in = '0;
  logic done;
  logic [STAT_WIDTH-1:0] status;
  logic signed [31:0] data_out;
  logic [7:0] priority_out;
  logic [OCC_WIDTH-1:0] occupancy;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  bounded_priority_queue dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .data_in(data_in), .priority_in(priority_in), .done(done), .status(status),
    .data_out(data_out), .priority_out(priority_out), .occupancy(occupancy),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow copy of the sorted slot array
  logic [31:0] shadow_data [DEPTH_DEF];
  logic [7:0] shadow_prio [DEPTH_DEF];
  int shadow_count = 0;
  logic [CAP_WIDTH-1:0] shadow_cap = CAP_RESET;

  queue_result_t pending_results[$];
  plan_row_t plan[$];
  int mismatches = 0;
  int stall_cycles = 0;

  function automatic queue_result_t queue_model_step(logic m, logic [31:0] d,
                                                     logic [7:0] p);
    queue_result_t r;
    int limit;
    int pos;
    r = '{status: STATUS_OK, data_out: '0, priority_out: '0, occupancy: '0};
    limit = (shadow_cap > DEPTH_DEF) ? DEPTH_DEF : int'(shadow_cap);
    if (m == MODE_ENQ) begin
      if (shadow_count >= limit) begin
        r.status = STATUS_OVERFLOW;
      end else begin
        // land behind every entry of equal or higher priority
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] >= p) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_data[i] = shadow_data[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_data[pos] = d;
        shadow_prio[pos] = p;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = STATUS_UNDERFLOW;
      end else begin
        r.data_out = shadow_data[0];
        r.priority_out = shadow_prio[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_data[i-1] = shadow_data[i];
          shadow_prio[i-1] = shadow_prio[i];
        end
        shadow_count--;
      end
    end
    r.occupancy = OCC_WIDTH'(shadow_count);
    return r;
  endfunction

  function automatic plan_row_t cmd_row(logic m, logic [31:0] d, logic [7:0] p);
    plan_row_t r;
    r = '0;
    r.mode = m;
    r.data = d;
    r.prio = p;
    return r;
  endfunction

  function automatic plan_row_t checked_row(logic m, logic [31:0] d, logic [7:0] p,
                                            logic [STAT_WIDTH-1:0] st, logic [31:0] dout,
                                            logic [7:0] pout, logic [OCC_WIDTH-1:0] occ);
    plan_row_t r;
    r = cmd_row(m, d, p);
    r.typed = 1'b1;
    r.res = '{status: st, data_out: dout, priority_out: pout, occupancy: occ};
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [APB_AW-1:0] addr, logic [CAP_WIDTH-1:0] c);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.addr = addr;
    r.cap = c;
    return r;
  endfunction

  task automatic note_field(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // write a register, then read capacity back
  task automatic write_register(input logic [APB_AW-1:0] addr,
                                input logic [CAP_WIDTH-1:0] value);
    wait_results_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {27'($urandom_range(32'h07ff_ffff, 0)), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if ((addr >> 2) == REG_CAPACITY) shadow_cap = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= CAP_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    note_field("capacity readback", {27'b0, shadow_cap}, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic issue_command(input plan_row_t row, input int idle_pct);
    int gap;
    queue_result_t predicted;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= row.mode;
    data_in <= row.data;
    priority_in <= row.prio;
    do @(posedge clk); while (busy);
    predicted = queue_model_step(row.mode, row.data, row.prio);
    pending_results.push_back(row.typed ? row.res : predicted);
  endtask

  always @(posedge clk) begin : watch_results
    queue_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        note_field("status", 32'(want.status), 32'(status));
        note_field("data_out", want.data_out, data_out);
        note_field("priority_out", 32'(want.priority_out), 32'(priority_out));
        note_field("occupancy", 32'(want.occupancy), 32'(occupancy));
      end
    end
    if ((start && !busy) || done || (psel && penable)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t row;
    int idle_pct;
    int enq_pct;
    logic [7:0] p;

    // ties, extremes of data and priority, underflow on empty
    plan.push_back(checked_row(MODE_DEQ, 32'h1234_5678, 8'hAA, STATUS_UNDERFLOW, 0, 0, 0));
    plan.push_back(cmd_row(MODE_ENQ, 32'h7FFF_FFFF, 8'd255));
    plan.push_back(cmd_row(MODE_ENQ, 32'h8000_0000, 8'd0));
    plan.push_back(cmd_row(MODE_ENQ, 32'hFFFF_FFFF, 8'd255));
    plan.push_back(checked_row(MODE_ENQ, 32'h0, 8'd128, STATUS_OK, 0, 0, 4));
    plan.push_back(cmd_row(MODE_ENQ, 32'h5555_5555, 8'd0));
    plan.push_back(checked_row(MODE_DEQ, 0, 0, STATUS_OK, 32'h7FFF_FFFF, 8'd255, 4));
    plan.push_back(checked_row(MODE_DEQ, 0, 0, STATUS_OK, 32'hFFFF_FFFF, 8'd255, 3));
    plan.push_back(checked_row(MODE_DEQ, 0, 0, STATUS_OK, 32'h0, 8'd128, 2));
    plan.push_back(checked_row(MODE_DEQ, 0, 0, STATUS_OK, 32'h8000_0000, 8'd0, 1));
    plan.push_back(checked_row(MODE_DEQ, 0, 0, STATUS_OK, 32'h5555_5555, 8'd0, 0));
    plan.push_back(checked_row(MODE_DEQ, 0, 0, STATUS_UNDERFLOW, 0, 0, 0));
    // zero capacity: always full
    plan.push_back(cfg_row(CAP_ADDR, 5'd0));
    plan.push_back(checked_row(MODE_ENQ, 32'hAAAA_AAAA, 8'd7, STATUS_OVERFLOW, 0, 0, 0));
    plan.push_back(checked_row(MODE_DEQ, 0, 0, STATUS_UNDERFLOW, 0, 0, 0));
    plan.push_back(cfg_row(CAP_ADDR, 5'd1));
    plan.push_back(checked_row(MODE_ENQ, 32'd1, 8'd1, STATUS_OK, 0, 0, 1));
    plan.push_back(checked_row(MODE_ENQ, 32'd2, 8'd200, STATUS_OVERFLOW, 0, 0, 1));
    // write to an unmapped address must leave capacity alone
    plan.push_back(cfg_row(SPARE_ADDR, 5'd16));
    plan.push_back(checked_row(MODE_ENQ, 32'd3, 8'd3, STATUS_OVERFLOW, 0, 0, 1));
    plan.push_back(checked_row(MODE_DEQ, 0, 0, STATUS_OK, 32'd1, 8'd1, 0));
    plan.push_back(checked_row(MODE_ENQ, 32'd3, 8'd3, STATUS_OK, 0, 0, 1));
    plan.push_back(checked_row(MODE_DEQ, 0, 0, STATUS_OK, 32'd3, 8'd3, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) write_register(row.addr, row.cap);
      else issue_command(row, 0);
    end

    // random segments; capacity changes leave held entries in place
    enq_pct = 50;
    for (int seg = 0; seg < 6; seg++) begin
      write_register(CAP_ADDR, SEG_CAPS[seg]);
      idle_pct = (seg < 2) ? 28 : (seg < 4) ? 47 : 0;
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // swing between filling and draining to reach full and empty
        if (n % 30 == 0) begin
          case ($urandom_range(2))
            0: enq_pct = 85;
            1: enq_pct = 50;
            default: enq_pct = 15;
          endcase
        end
        p = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
        row = cmd_row(($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ,
                      $urandom(), p);
        issue_command(row, idle_pct);
      end
    end

    wait_results_drained();
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
